[rtl/core/mdbfa_pkg.sv]
// ----------------------------------------------------------------------------
// MDB frame assembler package
// Shared widths, control byte codes, queue command and store write types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mdbfa_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 6;
	localparam int GAP_W  = 16;

	localparam logic [GAP_W-1:0] GAP_RESET = 16'd1000;
	localparam logic [GAP_W-1:0] IDLE_MAX  = 16'hFFFF;

	// Single-byte control values that close a frame on their own.
	localparam logic [BYTE_W-1:0] CTRL_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] CTRL_ONES = 8'hFF;
	localparam logic [BYTE_W-1:0] CTRL_ALT  = 8'hAA;

	// Item kinds on the input channel.
	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// One closed frame waiting to be played out.
	typedef struct packed {
		logic              bank;
		logic [POS_W-1:0]  len;
		logic [BYTE_W-1:0] expected;
		logic [BYTE_W-1:0] actual;
		logic              good;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_push_t;

	// One write into the frame store.
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [POS_W-1:0]  idx;
		logic [BYTE_W-1:0] value;
		logic              mode;
	} store_wr_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	function automatic logic is_control(input logic [BYTE_W-1:0] v);
		return (v == CTRL_ZERO) || (v == CTRL_ONES) || (v == CTRL_ALT);
	endfunction

endpackage

`default_nettype wire

[rtl/core/mdbfa_front.sv]
// ----------------------------------------------------------------------------
// MDB frame assembler front end
// Accepts words and ticks, tracks the open frame, writes the frame store and
// queues a command for every frame that closes and is to be emitted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdbfa_front #(
	parameter int MAX_FRAME_BYTES = 36
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [mdbfa_pkg::GAP_W-1:0] cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       kind,
	input  wire logic [7:0]                 word_value,
	input  wire logic                       word_mode,
	input  wire logic                       back_free,
	output mdbfa_pkg::store_wr_t            store_wr,
	output mdbfa_pkg::cmd_push_t            push_a,
	output mdbfa_pkg::cmd_push_t            push_b
);
	import mdbfa_pkg::*;

	localparam logic [POS_W-1:0] MaxFill = POS_W'(MAX_FRAME_BYTES);

	logic [GAP_W-1:0]  gap_q;
	logic [POS_W-1:0]  fill_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] last_q;
	logic              first_q;
	logic              later_q;
	logic [GAP_W-1:0]  idle_q;
	logic              bank_q;

	logic              accept;
	logic              is_word;
	logic              is_tick;
	logic [GAP_W-1:0]  idle_inc;
	logic              close_tick;
	logic              close_word;
	logic              close_a;
	logic              emit_ok;
	logic              bank_b;
	logic [POS_W-1:0]  fill0;
	logic [BYTE_W-1:0] sum0;
	logic              first0;
	logic              later0;
	logic [POS_W-1:0]  fill1;
	logic [BYTE_W-1:0] sum1;
	logic              first1;
	logic              later1;
	logic              close_b;
	logic [BYTE_W-1:0] expected_b;

	// Items are taken only when the back end and the queue are drained.
	assign in_ready = back_free;
	assign accept   = in_valid && in_ready;
	assign is_word  = accept && (kind == KIND_WORD);
	assign is_tick  = accept && (kind == KIND_TICK);

	// Close decisions for the frame that is open now.
	always_comb begin
		idle_inc   = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
		close_tick = is_tick && (fill_q != '0) && (idle_inc >= gap_q);
		close_word = is_word && (fill_q != '0) && (word_mode || (fill_q >= MaxFill));
		close_a    = close_tick || close_word;
		emit_ok    = (fill_q >= 6'd2) || is_control(last_q);

		push_a.valid        = close_a && emit_ok;
		push_a.cmd.bank     = bank_q;
		push_a.cmd.len      = fill_q;
		push_a.cmd.actual   = last_q;
		push_a.cmd.expected = (fill_q == 6'd1) ? last_q : sum_q - last_q;
		push_a.cmd.good     = (push_a.cmd.expected == last_q);

		bank_b = bank_q ^ push_a.valid;
	end

	// Frame state after the new word is stored, and the second close check.
	always_comb begin
		fill0  = close_word ? '0 : fill_q;
		sum0   = close_word ? '0 : sum_q;
		first0 = close_word ? 1'b0 : first_q;
		later0 = close_word ? 1'b0 : later_q;
		fill1  = fill0 + 6'd1;
		sum1   = sum0 + word_value;
		first1 = (fill0 == '0) ? word_mode : first0;
		later1 = later0 || ((fill0 != '0) && word_mode);

		close_b = is_word && (((fill0 == '0) && is_control(word_value)) ||
			((fill1 >= 6'd2) && first1 && !later1 && (sum0 == word_value)));
		expected_b = (fill0 == '0) ? word_value : sum0;

		push_b.valid        = close_b;
		push_b.cmd.bank     = bank_b;
		push_b.cmd.len      = fill1;
		push_b.cmd.actual   = word_value;
		push_b.cmd.expected = expected_b;
		push_b.cmd.good     = (expected_b == word_value);

		store_wr.en    = is_word;
		store_wr.bank  = bank_b;
		store_wr.idx   = fill0;
		store_wr.value = word_value;
		store_wr.mode  = word_mode;
	end

	// Gap register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
		end else if (cfg_wr_en) begin
			gap_q <= cfg_wr_data;
		end
	end

	// Open frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			sum_q   <= '0;
			first_q <= 1'b0;
			later_q <= 1'b0;
			idle_q  <= '0;
			bank_q  <= 1'b0;
		end else if (is_word) begin
			idle_q <= '0;
			if (close_b) begin
				fill_q  <= '0;
				sum_q   <= '0;
				first_q <= 1'b0;
				later_q <= 1'b0;
				bank_q  <= ~bank_b;
			end else begin
				fill_q  <= fill1;
				sum_q   <= sum1;
				first_q <= first1;
				later_q <= later1;
				bank_q  <= bank_b;
			end
		end else if (close_tick) begin
			fill_q  <= '0;
			sum_q   <= '0;
			first_q <= 1'b0;
			later_q <= 1'b0;
			idle_q  <= '0;
			bank_q  <= bank_b;
		end else if (is_tick && (fill_q != '0)) begin
			idle_q <= idle_inc;
		end
	end

	// Most recent stored byte, the check byte of a frame closed by a tick or by the next word.
	always_ff @(posedge clk) begin
		if (is_word) begin
			last_q <= word_value;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MaxFill)
		else $error("frame fill count exceeds store size");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push_a.valid || push_b.valid) |-> accept)
		else $error("close command without an accepted item");

endmodule

`default_nettype wire

[rtl/core/mdbfa_cmd_queue.sv]
// ----------------------------------------------------------------------------
// MDB frame assembler command queue
// Two-entry queue of closed frames; takes up to two commands in one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdbfa_cmd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  mdbfa_pkg::cmd_push_t   push_a,
	input  mdbfa_pkg::cmd_push_t   push_b,
	input  wire logic              pop,
	output logic                   empty,
	output mdbfa_pkg::cmd_t        head
);
	import mdbfa_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [1:0] n_push;
	cmd_t       first_cmd;

	// Compact the two push slots so the earlier close lands first.
	always_comb begin
		n_push    = {1'b0, push_a.valid} + {1'b0, push_b.valid};
		first_cmd = push_a.valid ? push_a.cmd : push_b.cmd;
		empty     = (count_q == 2'd0);
		head      = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entry_q[wr_ptr_q] <= first_cmd;
		end
		if (n_push == 2'd2) begin
			entry_q[~wr_ptr_q] <= push_b.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ n_push[0];
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q  <= count_q + n_push - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + n_push) <= 3'd2)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue pop while empty");

endmodule

`default_nettype wire

[rtl/core/mdbfa_back.sv]
// ----------------------------------------------------------------------------
// MDB frame assembler back end
// Holds the two-bank frame store and plays each queued frame out one byte
// per cycle while the output is not held, through a read stage and an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdbfa_back #(
	parameter int MAX_FRAME_BYTES = 36
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  mdbfa_pkg::store_wr_t  store_wr,
	input  wire logic             q_empty,
	input  mdbfa_pkg::cmd_t       q_head,
	output logic                  q_pop,
	output logic                  busy,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            byte_value,
	output logic                  byte_mode,
	output logic [5:0]            byte_position,
	output logic                  frame_last,
	output logic [5:0]            frame_length,
	output logic                  checksum_good,
	output logic [7:0]            check_calc,
	output logic [7:0]            check_recv
);
	import mdbfa_pkg::*;

	localparam int               AW      = $clog2(2 * MAX_FRAME_BYTES);
	localparam int               Depth   = 2 * MAX_FRAME_BYTES;
	localparam logic [AW-1:0]    BankOfs = AW'(MAX_FRAME_BYTES);

	logic [BYTE_W:0]   store_mem [Depth];

	back_state_t       state_q;
	back_state_t       state_d;
	cmd_t              cmd_q;
	logic [POS_W-1:0]  pos_q;

	logic              valid_s1;
	logic [BYTE_W:0]   rdata_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              last_s1;
	cmd_t              cmd_s1;

	logic              adv_s1;
	logic              issue;
	logic              issue_last;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;

	// Read stage moves on when the output register is empty or being taken.
	always_comb begin
		adv_s1     = valid_s1 && (!out_valid || out_ready);
		issue      = (state_q == BK_RUN) && (!valid_s1 || adv_s1);
		issue_last = (pos_q == cmd_q.len - 6'd1);
		waddr      = store_wr.bank ? AW'(store_wr.idx) + BankOfs : AW'(store_wr.idx);
		raddr      = cmd_q.bank ? AW'(pos_q) + BankOfs : AW'(pos_q);
		busy       = (state_q == BK_RUN) || valid_s1 || out_valid;
	end

	// Sequencer over the bytes of one frame.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (issue && issue_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
			pos_q <= '0;
		end else if (issue) begin
			pos_q <= pos_q + 6'd1;
		end
	end

	// Frame store: one write port for the front end, one registered read.
	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			store_mem[waddr] <= {store_wr.mode, store_wr.value};
		end
		if (issue) begin
			rdata_s1 <= store_mem[raddr];
			pos_s1   <= pos_q;
			last_s1  <= issue_last;
			cmd_s1   <= cmd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			byte_value    <= rdata_s1[BYTE_W-1:0];
			byte_mode     <= rdata_s1[BYTE_W];
			byte_position <= pos_s1;
			frame_last    <= last_s1;
			frame_length  <= last_s1 ? cmd_s1.len : '0;
			checksum_good <= last_s1 && cmd_s1.good;
			check_calc    <= last_s1 ? cmd_s1.expected : '0;
			check_recv    <= last_s1 ? cmd_s1.actual : '0;
		end
	end

	a_last_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (frame_length == byte_position + 6'd1))
		else $error("final item length does not match its position");

	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> !busy)
		else $error("frame store written while a frame plays out");

endmodule

`default_nettype wire

[rtl/core/mdb_frame_assembler_core.sv]
// ----------------------------------------------------------------------------
// MDB frame assembler
// Gathers decoded 9-bit MDB words into frames, closes them on mode bit, full
// store, control byte, complete master frame or idle gap, and emits each closed
// frame but a lone non-control byte as a run of bytes with length and sum check verdict.
// ----------------------------------------------------------------------------
// Path: a closed frame is queued, popped by the sequencer, read from the store and registered.
// Throughput: one item per cycle while nothing closes; a closing item holds
// the input until its frame has played out and the output register is empty.
// Reset: arst_n clears all control state and loads the gap register with
// 1000; the frame store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mdb_frame_assembler_core #(
	parameter int MAX_FRAME_BYTES = 36
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  word_value,
	input  wire logic        word_mode,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       byte_value,
	output logic             byte_mode,
	output logic [5:0]       byte_position,
	output logic             frame_last,
	output logic [5:0]       frame_length,
	output logic             checksum_good,
	output logic [7:0]       check_calc,
	output logic [7:0]       check_recv
);
	import mdbfa_pkg::*;

	store_wr_t store_wr;
	cmd_push_t push_a;
	cmd_push_t push_b;
	cmd_t      q_head;
	logic      q_empty;
	logic      q_pop;
	logic      back_busy;
	logic      back_free;

	// The front end takes items only when no frame is pending or playing.
	assign back_free = q_empty && !back_busy;

	mdbfa_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.word_value (word_value),
		.word_mode  (word_mode),
		.back_free  (back_free),
		.store_wr   (store_wr),
		.push_a     (push_a),
		.push_b     (push_b)
	);

	mdbfa_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push_a(push_a),
		.push_b(push_b),
		.pop   (q_pop),
		.empty (q_empty),
		.head  (q_head)
	);

	mdbfa_back #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.store_wr     (store_wr),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.busy         (back_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_value   (byte_value),
		.byte_mode    (byte_mode),
		.byte_position(byte_position),
		.frame_last   (frame_last),
		.frame_length (frame_length),
		.checksum_good(checksum_good),
		.check_calc   (check_calc),
		.check_recv   (check_recv)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// MDB frame assembler testbench
// Feeds decoded words and time ticks into the frame assembler, keeps its own
// model of the open frame to predict every emitted byte, and checks each
// output byte against the oldest prediction. Directed tests cover control
// bytes, master frames, dropped lone bytes, a full store and the gap timer at
// zero, one, its reset value and its widest setting; random traffic follows
// under three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mdbfa_pkg::*;

	localparam int FRAME_DEPTH = 36;
	localparam int STALL_CYCLES = 300;

	// One emitted byte as the checker sees it.
	typedef struct packed {
		logic [7:0] value;
		logic       mode;
		logic [5:0] pos;
		logic       last;
		logic [5:0] len;
		logic       good;
		logic [7:0] sum_expected;
		logic [7:0] sum_actual;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  word_value;
	logic        word_mode;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte_value;
	logic        byte_mode;
	logic [5:0]  byte_position;
	logic        frame_last;
	logic [5:0]  frame_length;
	logic        checksum_good;
	logic [7:0]  check_calc;
	logic [7:0]  check_recv;

	// Model of the frame being gathered.
	logic [7:0]  held_bytes [FRAME_DEPTH];
	logic        held_modes [FRAME_DEPTH];
	int          held_count;
	logic [7:0]  byte_sum;
	logic        lead_mode;
	logic        trailing_mode;
	int          idle_ticks;
	logic [15:0] gap_ticks;

	frame_byte_t frame_bytes_due [$];
	int          mismatch_count = 0;
	int          useful_items;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          stall_requests;
	int          stall_served = 0;
	int          stall_left = 0;

	mdb_frame_assembler_core #(
		.MAX_FRAME_BYTES(FRAME_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.word_value(word_value),
		.word_mode(word_mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_value(byte_value),
		.byte_mode(byte_mode),
		.byte_position(byte_position),
		.frame_last(frame_last),
		.frame_length(frame_length),
		.checksum_good(checksum_good),
		.check_calc(check_calc),
		.check_recv(check_recv)
	);

	always #6 clk = ~clk;

	function automatic logic ends_alone(input logic [7:0] v);
		return (v == CTRL_ZERO) || (v == CTRL_ONES) || (v == CTRL_ALT);
	endfunction

	// Emits the open frame as expected bytes and empties the frame.
	// A lone byte that is not a control value leaves nothing.
	function automatic void close_held_frame();
		int i;
		logic [7:0] act;
		logic [7:0] exp_sum;
		logic ok;
		frame_byte_t fb;
		if (held_count > 0) begin
			act = held_bytes[held_count-1];
			if (held_count == 1) begin
				exp_sum = act;
				ok = 1'b1;
			end else begin
				exp_sum = byte_sum - act;
				ok = (exp_sum == act);
			end
			if (held_count > 1 || ends_alone(act)) begin
				for (i = 0; i < held_count; i++) begin
					fb.value = held_bytes[i];
					fb.mode = held_modes[i];
					fb.pos = 6'(i);
					fb.last = (i == held_count - 1);
					fb.len = fb.last ? 6'(held_count) : 6'd0;
					fb.good = fb.last && ok;
					fb.sum_expected = fb.last ? exp_sum : 8'd0;
					fb.sum_actual = fb.last ? act : 8'd0;
					frame_bytes_due.push_back(fb);
				end
			end
		end
		held_count = 0;
		byte_sum = 8'd0;
		lead_mode = 1'b0;
		trailing_mode = 1'b0;
		idle_ticks = 0;
	endfunction

	// Applies one accepted item to the frame model.
	function automatic void track_item(input logic k, input logic [7:0] v, input logic m);
		logic [7:0] check;
		if (k == KIND_TICK) begin
			if (held_count > 0) begin
				useful_items++;
				if (idle_ticks < int'(IDLE_MAX))
					idle_ticks++;
				if (idle_ticks >= gap_ticks)
					close_held_frame();
			end
			return;
		end
		useful_items++;
		if (m && held_count > 0)
			close_held_frame();
		if (held_count >= FRAME_DEPTH)
			close_held_frame();
		held_bytes[held_count] = v;
		held_modes[held_count] = m;
		if (held_count == 0)
			lead_mode = m;
		else if (m)
			trailing_mode = 1'b1;
		held_count++;
		byte_sum = byte_sum + v;
		idle_ticks = 0;
		check = byte_sum - held_bytes[held_count-1];
		if (held_count == 1 && ends_alone(held_bytes[0]))
			close_held_frame();
		else if (held_count >= 2 && lead_mode && !trailing_mode &&
				check == held_bytes[held_count-1])
			close_held_frame();
	endfunction

	function automatic string describe(input frame_byte_t b);
		return $sformatf("value %h mode %b pos %0d last %b len %0d good %b exp %h act %h",
			b.value, b.mode, b.pos, b.last, b.len, b.good, b.sum_expected, b.sum_actual);
	endfunction

	// Offers one item, with random idle cycles first, and waits until it is taken.
	task automatic offer_item(input logic k, input logic [7:0] v, input logic m);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		word_value <= v;
		word_mode <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_item(k, v, m);
	endtask

	task automatic offer_ticks(input int count);
		repeat (count)
			offer_item(KIND_TICK, 8'h00, 1'b0);
	endtask

	// Stops offering and waits until every predicted byte has come out.
	task automatic wait_for_quiet();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_bytes_due.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_gap(input logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		gap_ticks = v;
	endtask

	// Control bytes alone, a dropped lone byte and a two-byte master frame.
	task automatic test_control_bytes();
		offer_item(KIND_WORD, CTRL_ZERO, 1'b0);
		offer_item(KIND_WORD, CTRL_ONES, 1'b1);
		offer_item(KIND_WORD, CTRL_ALT, 1'b0);
		offer_item(KIND_WORD, 8'h55, 1'b1);
		offer_item(KIND_WORD, 8'h56, 1'b1);
		offer_item(KIND_WORD, CTRL_ALT, 1'b0);
		offer_item(KIND_WORD, 8'h01, 1'b1);
		offer_item(KIND_WORD, 8'h01, 1'b0);
	endtask

	// Good master frames at byte extremes, then one with a bad check byte
	// that a following address word closes.
	task automatic test_master_frames();
		offer_item(KIND_WORD, 8'h80, 1'b1);
		offer_item(KIND_WORD, 8'h00, 1'b0);
		offer_item(KIND_WORD, 8'h80, 1'b0);
		offer_item(KIND_WORD, 8'hFE, 1'b1);
		offer_item(KIND_WORD, 8'hFF, 1'b0);
		offer_item(KIND_WORD, 8'hFD, 1'b0);
		offer_item(KIND_WORD, 8'h10, 1'b1);
		offer_item(KIND_WORD, 8'h20, 1'b0);
		offer_item(KIND_WORD, 8'h31, 1'b0);
		offer_item(KIND_WORD, 8'h7F, 1'b1);
	endtask

	// At the reset gap a short run of ticks leaves the frame open; an
	// address control byte then closes it and closes itself. Ticks with
	// nothing open are ignored.
	task automatic test_gap_default();
		offer_item(KIND_WORD, 8'h21, 1'b0);
		offer_item(KIND_WORD, 8'h22, 1'b0);
		offer_ticks(40);
		offer_item(KIND_WORD, CTRL_ZERO, 1'b1);
		offer_ticks(3);
	endtask

	// A full store closes on the next word, which is a control byte and
	// closes at once too: the largest burst of output bytes.
	task automatic test_full_store();
		int i;
		for (i = 0; i < FRAME_DEPTH; i++)
			offer_item(KIND_WORD, 8'h11 + 8'(i), 1'b0);
		offer_item(KIND_WORD, CTRL_ONES, 1'b0);
	endtask

	// The receiver holds off for a long stretch while frames keep coming,
	// so the block backs up and stalls its input.
	task automatic test_input_stall();
		int f;
		int j;
		logic [7:0] sum;
		logic [7:0] b;
		stall_requests++;
		for (f = 0; f < 6; f++) begin
			sum = 8'h40 + 8'(f);
			offer_item(KIND_WORD, sum, 1'b1);
			for (j = 0; j < 8; j++) begin
				b = 8'($urandom);
				sum = sum + b;
				offer_item(KIND_WORD, b, 1'b0);
			end
			offer_item(KIND_WORD, sum, 1'b0);
		end
	endtask

	// With a zero gap the first tick closes any open frame.
	task automatic test_zero_gap();
		wait_for_quiet();
		write_gap(16'd0);
		offer_ticks(2);
		offer_item(KIND_WORD, 8'h44, 1'b0);
		offer_ticks(1);
		offer_item(KIND_WORD, 8'h44, 1'b1);
		offer_item(KIND_WORD, 8'h45, 1'b0);
		offer_ticks(2);
	endtask

	task automatic test_gap_one();
		wait_for_quiet();
		write_gap(16'd1);
		offer_item(KIND_WORD, 8'h12, 1'b1);
		offer_item(KIND_WORD, 8'h34, 1'b0);
		offer_ticks(2);
	endtask

	// The widest gap holds the frame open through a run of ticks until an
	// address word closes it.
	task automatic test_gap_max();
		wait_for_quiet();
		write_gap(IDLE_MAX);
		offer_item(KIND_WORD, 8'h31, 1'b0);
		offer_item(KIND_WORD, 8'h32, 1'b0);
		offer_ticks(60);
		offer_item(KIND_WORD, 8'h33, 1'b1);
		offer_ticks(2);
	endtask

	// Mostly master frames with random content, mixed with control bytes,
	// tick runs, stray words and address-free runs.
	task automatic test_random_traffic(input int count);
		int goal;
		int r;
		int n;
		int j;
		logic [7:0] sum;
		logic [7:0] b;
		goal = useful_items + count;
		while (useful_items < goal) begin
			r = $urandom_range(99);
			if (r < 55) begin
				sum = 8'($urandom);
				offer_item(KIND_WORD, sum, 1'b1);
				n = ($urandom_range(19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
				for (j = 0; j < n; j++) begin
					b = 8'($urandom);
					sum = sum + b;
					offer_item(KIND_WORD, b, 1'b0);
				end
				if ($urandom_range(9) < 8)
					offer_item(KIND_WORD, sum, 1'b0);
				else
					offer_item(KIND_WORD, sum ^ (8'd1 << $urandom_range(7)), 1'b0);
			end else if (r < 65) begin
				case ($urandom_range(2))
					0: b = CTRL_ZERO;
					1: b = CTRL_ONES;
					default: b = CTRL_ALT;
				endcase
				offer_item(KIND_WORD, b, 1'($urandom));
			end else if (r < 80) begin
				n = $urandom_range(1, int'(gap_ticks) + 2);
				for (j = 0; j < n; j++)
					offer_item(KIND_TICK, 8'($urandom), 1'($urandom));
			end else if (r < 90) begin
				offer_item(KIND_WORD, 8'($urandom), 1'($urandom));
			end else begin
				n = $urandom_range(1, 8);
				for (j = 0; j < n; j++)
					offer_item(KIND_WORD, 8'($urandom), 1'b0);
			end
		end
	endtask

	// Receiver: random back-pressure, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (stall_served != stall_requests) begin
			stall_left = STALL_CYCLES;
			stall_served = stall_requests;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Each accepted output byte is checked against the oldest prediction.
	always @(posedge clk) begin : check_output
		frame_byte_t got;
		frame_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{byte_value, byte_mode, byte_position, frame_last, frame_length,
				checksum_good, check_calc, check_recv};
			if (frame_bytes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: output byte with none predicted: %s", $realtime, describe(got));
			end else begin
				want = frame_bytes_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: byte mismatch", $realtime);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(got));
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 16'd0;
		in_valid = 1'b0;
		kind = KIND_WORD;
		word_value = 8'd0;
		word_mode = 1'b0;
		held_count = 0;
		byte_sum = 8'd0;
		lead_mode = 1'b0;
		trailing_mode = 1'b0;
		idle_ticks = 0;
		gap_ticks = GAP_RESET;
		useful_items = 0;
		stall_requests = 0;
		send_idle_pct = 33;
		recv_idle_pct = 47;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_control_bytes();
		test_master_frames();
		test_gap_default();
		test_full_store();
		test_input_stall();
		wait_for_quiet();
		write_gap(16'($urandom_range(2, 6)));
		test_random_traffic(100);

		send_idle_pct = 47;
		recv_idle_pct = 33;
		test_zero_gap();
		test_gap_one();
		wait_for_quiet();
		write_gap(16'($urandom_range(1, 4)));
		test_random_traffic(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_gap_max();
		wait_for_quiet();
		write_gap(16'($urandom_range(3, 10)));
		test_random_traffic(100);
		wait_for_quiet();

		// Predictions still waiting at the end are failures as well.
		if (mismatch_count == 0 && frame_bytes_due.size() == 0)
			$display("mdb_frame_assembler_core test passed");
		else
			$display("mdb_frame_assembler_core test failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(20_000_000);
		$display("mdb_frame_assembler_core test failed");
		$finish;
	end

endmodule
